@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("%m: forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, expr)

`endif

`endif

@@ hdl/slr_pkg.sv @@
// ---------------------------------------------------------------------------
// slr_pkg
// shared types and constants of the streaming literal replace block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package slr_pkg;

    // register file and result limits
    localparam int REG_BYTES       = 16;
    localparam int RESULT_CAP      = 32;
    localparam int DATA_CAP        = RESULT_CAP - 1;
    localparam int PATTERN_MAX_DEF = 16;
    localparam int REPLACE_MAX_DEF = 16;

    // configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int LEN_W       = 5;
    localparam int LIMIT_W     = 16;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd256;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_PATTERN_LEN  = 3'd2,
        REG_REPLACE_LOW  = 3'd3,
        REG_REPLACE_HIGH = 3'd4,
        REG_REPLACE_LEN  = 3'd5,
        REG_OUTPUT_LIMIT = 3'd6
    } cfg_reg_t;

    // input transfer payload
    typedef struct packed {
        logic [7:0] char_in;
        logic       last_in;
    } slr_in_t;

    // result transfer payload
    typedef struct packed {
        logic [7:0] char_out;
        logic       run_last;
        logic       string_end;
        logic       overflow;
    } slr_out_t;

endpackage

@@ hdl/stream_literal_replace.sv @@
// ---------------------------------------------------------------------------
// stream_literal_replace
// streaming find-and-replace-all of a literal pattern on a byte stream
// ---------------------------------------------------------------------------
// One input byte is taken per cycle when it causes at most one result: the
// window insert, the parallel pattern compare and the window shift all sit
// between the input register and the result queue. A match emits the
// saturated replace_len bytes of the replacement one byte per cycle, the
// later ones from the replace state. The final byte of a string then
// flushes the held window bytes and sends the terminator. After the pattern
// length is changed between items, the held window head is resolved one
// resolution at a time before the new byte (a match removes a whole pattern
// length of bytes at once and may go on in the replace state); with a zero
// pattern length the held bytes are sent one by one first. Results of an
// item are released from a 32-entry result queue once the item is finished,
// because overflow and run_last depend on the whole item; then one result
// per cycle leaves through the output register while m_ready allows. The
// item in work waits while the result queue or the step queue is full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module stream_literal_replace
    import slr_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int REPLACE_MAX = REPLACE_MAX_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration writes
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // input stream
    input  logic                   s_valid,
    output logic                   s_ready,
    input  slr_in_t                s_payload,
    // result stream
    output logic                   m_valid,
    input  logic                   m_ready,
    output slr_out_t               m_payload
);

    // effective sizes
    localparam int WIN_DEPTH  = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;
    localparam int REP_DEPTH  = (REPLACE_MAX < REG_BYTES) ? REPLACE_MAX : REG_BYTES;
    localparam int FILL_W     = $clog2(WIN_DEPTH + 1);
    localparam int RLEN_W     = $clog2(REP_DEPTH + 1);
    localparam int REP_IDX_W  = (REP_DEPTH > 1) ? $clog2(REP_DEPTH) : 1;
    localparam int FIFO_DEPTH = RESULT_CAP;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;
    localparam int STEP_W     = $clog2(RESULT_CAP + 1);

    typedef enum logic [1:0] {
        ST_HEAD,
        ST_REPL,
        ST_FLUSH
    } gen_state_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       string_end;
    } entry_t;

    typedef struct packed {
        logic              overflow;
        logic [STEP_W-1:0] count;
    } step_t;

    // configuration registers
    logic [CFG_DATA_W-1:0] pat_lo_reg, pat_hi_reg, rep_lo_reg, rep_hi_reg;
    logic [LEN_W-1:0]      pat_len_reg, rep_len_reg;
    logic [LIMIT_W-1:0]    limit_reg;

    // input register
    slr_in_t in_reg;
    logic    in_full_reg, in_full_next;

    // generator state
    gen_state_t           state_reg, state_next;
    logic [7:0]           win_reg [WIN_DEPTH];
    logic [7:0]           win_next [WIN_DEPTH];
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [REP_IDX_W-1:0] rep_idx_reg, rep_idx_next;
    logic                 inserted_reg, inserted_next;
    logic [LIMIT_W-1:0]   emitted_reg, emitted_next;
    logic                 ovf_reg, ovf_next, ovf_step;
    logic [STEP_W-1:0]    step_cnt_reg, step_cnt_next, step_cnt_upd;

    // result queue and step queue
    entry_t            efifo_mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  efifo_wr_ptr_reg, efifo_rd_ptr_reg;
    logic [CNT_W-1:0]  efifo_cnt_reg;
    step_t             ffifo_mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  ffifo_wr_ptr_reg, ffifo_rd_ptr_reg;
    logic [CNT_W-1:0]  ffifo_cnt_reg;
    logic              efifo_wr, efifo_rd, ffifo_wr, ffifo_rd;
    entry_t            efifo_wdata;
    step_t             ffifo_wdata;

    // output register
    slr_out_t          m_payload_reg;
    logic              m_valid_reg;
    logic [STEP_W-1:0] out_idx_reg;
    logic              out_load, out_run_last;

    // pattern and replacement as bytes
    logic [2*CFG_DATA_W-1:0] pat_all, rep_all;
    logic [7:0] pat_byte [WIN_DEPTH];
    logic [7:0] rep_byte [REP_DEPTH];
    logic [FILL_W-1:0] plen;
    logic [RLEN_W-1:0] rlen;

    // datapath signals
    logic [7:0]        w [WIN_DEPTH];
    logic [7:0]        shift1 [WIN_DEPTH];
    logic [7:0]        shiftp [WIN_DEPTH];
    logic [FILL_W-1:0] wfill;
    logic              ins_now, hit, resolve, stall, go, tail, end_step;
    logic              put_req, put_term;
    logic [7:0]        put_char;

    // configuration write port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_lo_reg  <= '0;
            pat_hi_reg  <= '0;
            pat_len_reg <= '0;
            rep_lo_reg  <= '0;
            rep_hi_reg  <= '0;
            rep_len_reg <= '0;
            limit_reg   <= LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PATTERN_LOW:  pat_lo_reg  <= cfg_wdata;
                REG_PATTERN_HIGH: pat_hi_reg  <= cfg_wdata;
                REG_PATTERN_LEN:  pat_len_reg <= cfg_wdata[LEN_W-1:0];
                REG_REPLACE_LOW:  rep_lo_reg  <= cfg_wdata;
                REG_REPLACE_HIGH: rep_hi_reg  <= cfg_wdata;
                REG_REPLACE_LEN:  rep_len_reg <= cfg_wdata[LEN_W-1:0];
                REG_OUTPUT_LIMIT: limit_reg   <= cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // byte views of the pattern and replacement
    always_comb begin
        pat_all = {pat_hi_reg, pat_lo_reg};
        rep_all = {rep_hi_reg, rep_lo_reg};
        for (int i = 0; i < WIN_DEPTH; i++) begin
            pat_byte[i] = pat_all[8*i +: 8];
        end
        for (int i = 0; i < REP_DEPTH; i++) begin
            rep_byte[i] = rep_all[8*i +: 8];
        end
    end

    // saturated lengths
    always_comb begin
        if (pat_len_reg > LEN_W'(WIN_DEPTH)) begin
            plen = FILL_W'(WIN_DEPTH);
        end else begin
            plen = FILL_W'(pat_len_reg);
        end
        if (rep_len_reg > LEN_W'(REP_DEPTH)) begin
            rlen = RLEN_W'(REP_DEPTH);
        end else begin
            rlen = RLEN_W'(rep_len_reg);
        end
    end

    // input register
    assign s_ready = !in_full_reg || end_step;

    always_comb begin
        in_full_next = in_full_reg;
        if (s_valid && s_ready) begin
            in_full_next = 1'b1;
        end else if (end_step) begin
            in_full_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_full_reg <= 1'b0;
        end else begin
            in_full_reg <= in_full_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_payload;
        end
    end

    // working window: new byte inserted when the window is short of a match
    assign ins_now = (state_reg == ST_HEAD) && (plen != '0) && (fill_reg < plen);
    assign wfill   = ins_now ? fill_reg + FILL_W'(1) : fill_reg;
    assign resolve = (plen != '0) && (wfill >= plen);

    always_comb begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
            w[i] = (ins_now && (fill_reg == FILL_W'(i))) ? in_reg.char_in : win_reg[i];
        end
    end

    // parallel compare of the window head against the pattern
    always_comb begin
        hit = 1'b1;
        for (int i = 0; i < WIN_DEPTH; i++) begin
            if ((FILL_W'(i) < plen) && (w[i] != pat_byte[i])) begin
                hit = 1'b0;
            end
        end
    end

    // window shifted by one byte and by the pattern length
    always_comb begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
            shift1[i] = (i < WIN_DEPTH - 1) ? w[(i + 1) % WIN_DEPTH] : 8'h00;
            shiftp[i] = 8'h00;
            for (int k = 1; k < WIN_DEPTH - i; k++) begin
                if (plen == FILL_W'(k)) begin
                    shiftp[i] = w[i + k];
                end
            end
        end
    end

    // sequencer: at most one put per cycle
    assign stall = (efifo_cnt_reg == CNT_W'(FIFO_DEPTH)) ||
                   (ffifo_cnt_reg == CNT_W'(FIFO_DEPTH));
    assign go    = in_full_reg && !stall;

    always_comb begin
        state_next    = state_reg;
        win_next      = win_reg;
        fill_next     = fill_reg;
        rep_idx_next  = rep_idx_reg;
        inserted_next = inserted_reg;
        put_req       = 1'b0;
        put_term      = 1'b0;
        put_char      = 8'h00;
        tail          = 1'b0;
        end_step      = 1'b0;
        if (go) begin
            case (state_reg)
                ST_HEAD: begin
                    if (plen == '0) begin
                        // pass through: drain held bytes, then the new one
                        put_req = 1'b1;
                        if (fill_reg != '0) begin
                            put_char  = w[0];
                            win_next  = shift1;
                            fill_next = fill_reg - FILL_W'(1);
                        end else begin
                            put_char = in_reg.char_in;
                            tail     = 1'b1;
                        end
                    end else if (resolve) begin
                        if (hit) begin
                            win_next  = shiftp;
                            fill_next = wfill - plen;
                            if (rlen != '0) begin
                                put_req  = 1'b1;
                                put_char = rep_byte[0];
                            end
                            if (rlen > RLEN_W'(1)) begin
                                state_next    = ST_REPL;
                                rep_idx_next  = REP_IDX_W'(1);
                                inserted_next = ins_now;
                            end else begin
                                tail = ins_now;
                            end
                        end else begin
                            put_req   = 1'b1;
                            put_char  = w[0];
                            win_next  = shift1;
                            fill_next = wfill - FILL_W'(1);
                            tail      = ins_now;
                        end
                    end else begin
                        // byte held in the window
                        win_next  = w;
                        fill_next = wfill;
                        tail      = 1'b1;
                    end
                end
                ST_REPL: begin
                    put_req      = 1'b1;
                    put_char     = rep_byte[rep_idx_reg];
                    rep_idx_next = rep_idx_reg + REP_IDX_W'(1);
                    if ((RLEN_W'(rep_idx_reg) + RLEN_W'(1)) == rlen) begin
                        state_next = ST_HEAD;
                        tail       = inserted_reg;
                    end
                end
                ST_FLUSH: begin
                    put_req = 1'b1;
                    if (fill_reg != '0) begin
                        put_char  = w[0];
                        win_next  = shift1;
                        fill_next = fill_reg - FILL_W'(1);
                    end else begin
                        put_term   = 1'b1;
                        end_step   = 1'b1;
                        state_next = ST_HEAD;
                    end
                end
                default: begin
                    state_next = ST_HEAD;
                end
            endcase
            // new byte placed: finish the item or flush on the final byte
            if (tail) begin
                if (in_reg.last_in) begin
                    state_next = ST_FLUSH;
                end else begin
                    end_step = 1'b1;
                end
            end
        end
    end

    // put: output limit, per-item result cap, result queue write
    always_comb begin
        efifo_wr     = 1'b0;
        efifo_wdata  = '{char_out: put_char, string_end: put_term};
        ovf_step     = ovf_reg;
        emitted_next = emitted_reg;
        step_cnt_upd = step_cnt_reg;
        if (put_req) begin
            if (put_term) begin
                efifo_wr     = 1'b1;
                step_cnt_upd = step_cnt_reg + STEP_W'(1);
            end else if (emitted_reg >= limit_reg) begin
                ovf_step = 1'b1;
            end else if (step_cnt_reg < STEP_W'(DATA_CAP)) begin
                efifo_wr     = 1'b1;
                emitted_next = emitted_reg + LIMIT_W'(1);
                step_cnt_upd = step_cnt_reg + STEP_W'(1);
            end
        end
        ffifo_wr      = end_step && (step_cnt_upd != '0);
        ffifo_wdata   = '{overflow: ovf_step, count: step_cnt_upd};
        step_cnt_next = end_step ? '0 : step_cnt_upd;
        ovf_next      = ovf_step;
        if (end_step && in_reg.last_in) begin
            emitted_next = '0;
            ovf_next     = 1'b0;
        end
    end

    // generator state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_HEAD;
            fill_reg     <= '0;
            emitted_reg  <= '0;
            ovf_reg      <= 1'b0;
            step_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            emitted_reg  <= emitted_next;
            ovf_reg      <= ovf_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg      <= win_next;
        rep_idx_reg  <= rep_idx_next;
        inserted_reg <= inserted_next;
    end

    // output side: release only results of finished items
    assign out_load = (!m_valid_reg || m_ready) &&
                      (efifo_cnt_reg != '0) && (ffifo_cnt_reg != '0);
    assign out_run_last = (out_idx_reg + STEP_W'(1)) == ffifo_mem_reg[ffifo_rd_ptr_reg].count;
    assign efifo_rd = out_load;
    assign ffifo_rd = out_load && out_run_last;

    // result queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            efifo_wr_ptr_reg <= '0;
            efifo_rd_ptr_reg <= '0;
            efifo_cnt_reg    <= '0;
        end else begin
            if (efifo_wr) begin
                efifo_wr_ptr_reg <= efifo_wr_ptr_reg + PTR_W'(1);
            end
            if (efifo_rd) begin
                efifo_rd_ptr_reg <= efifo_rd_ptr_reg + PTR_W'(1);
            end
            case ({efifo_wr, efifo_rd})
                2'b10:   efifo_cnt_reg <= efifo_cnt_reg + CNT_W'(1);
                2'b01:   efifo_cnt_reg <= efifo_cnt_reg - CNT_W'(1);
                default: efifo_cnt_reg <= efifo_cnt_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (efifo_wr) begin
            efifo_mem_reg[efifo_wr_ptr_reg] <= efifo_wdata;
        end
    end

    // step queue: overflow flag and result count of each finished item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ffifo_wr_ptr_reg <= '0;
            ffifo_rd_ptr_reg <= '0;
            ffifo_cnt_reg    <= '0;
        end else begin
            if (ffifo_wr) begin
                ffifo_wr_ptr_reg <= ffifo_wr_ptr_reg + PTR_W'(1);
            end
            if (ffifo_rd) begin
                ffifo_rd_ptr_reg <= ffifo_rd_ptr_reg + PTR_W'(1);
            end
            case ({ffifo_wr, ffifo_rd})
                2'b10:   ffifo_cnt_reg <= ffifo_cnt_reg + CNT_W'(1);
                2'b01:   ffifo_cnt_reg <= ffifo_cnt_reg - CNT_W'(1);
                default: ffifo_cnt_reg <= ffifo_cnt_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (ffifo_wr) begin
            ffifo_mem_reg[ffifo_wr_ptr_reg] <= ffifo_wdata;
        end
    end

    // output register and position within the current item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            out_idx_reg <= '0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
                out_idx_reg <= out_run_last ? '0 : out_idx_reg + STEP_W'(1);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_payload_reg.char_out   <= efifo_mem_reg[efifo_rd_ptr_reg].char_out;
            m_payload_reg.string_end <= efifo_mem_reg[efifo_rd_ptr_reg].string_end;
            m_payload_reg.run_last   <= out_run_last;
            m_payload_reg.overflow   <= ffifo_mem_reg[ffifo_rd_ptr_reg].overflow;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // checks
    `ASSERT_NEVER(a_efifo_overrun, aclk, aresetn, efifo_wr && (efifo_cnt_reg == CNT_W'(FIFO_DEPTH)))
    `ASSERT_NEVER(a_ffifo_overrun, aclk, aresetn, ffifo_wr && (ffifo_cnt_reg == CNT_W'(FIFO_DEPTH)))
    `ASSERT_CLK(a_end_is_last, aclk, aresetn, (m_valid && m_payload.string_end) |-> m_payload.run_last)
    `ASSERT_CLK(a_fill_bound, aclk, aresetn, fill_reg <= FILL_W'(WIN_DEPTH))

endmodule

@@ test/slr_replace_checker.sv @@
// ---------------------------------------------------------------------------
// slr_replace_checker
// predicts and checks the result stream of the literal replace block
// ---------------------------------------------------------------------------
// Watches the register writes, the input stream and the result stream. It
// keeps its own copy of the registers and of the match window. For every
// accepted input transfer it works out the result transfers that follow.
// Each result transfer is compared field by field with the oldest pending
// one. Mismatches and extra results are counted; pending ones are reported.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module slr_replace_checker
    import slr_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int REPLACE_MAX = REPLACE_MAX_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  slr_in_t                s_payload,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  slr_out_t               m_payload,
    output int                     error_count,
    output int                     pending_count,
    output int                     byte_count,
    output int                     result_count,
    output int                     replace_count,
    output int                     overflow_strings
);

    // shadow registers
    logic [63:0]        pat_lo, pat_hi, rep_lo, rep_hi;
    logic [LEN_W-1:0]   pat_len, rep_len;
    logic [LIMIT_W-1:0] out_limit;

    // per-string state
    logic [7:0]  window_bytes [REG_BYTES];
    int unsigned window_fill;
    int unsigned emitted;
    bit          overflow_seen;

    // results of the transfer in work, then all pending results in order
    slr_out_t step_results[$];
    slr_out_t pending_results[$];

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 30)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic logic [7:0] byte_pick(input logic [63:0] lo, input logic [63:0] hi,
                                             input int i);
        return (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
    endfunction

    function automatic int clamp_len(input logic [LEN_W-1:0] v, input int maxp);
        int n;
        n = v;
        if (n > REG_BYTES) n = REG_BYTES;
        if (n > maxp) n = maxp;
        return n;
    endfunction

    task automatic clear_model();
        pat_lo        = '0;
        pat_hi        = '0;
        rep_lo        = '0;
        rep_hi        = '0;
        pat_len       = '0;
        rep_len       = '0;
        out_limit     = LIMIT_RESET;
        foreach (window_bytes[i]) window_bytes[i] = '0;
        window_fill   = 0;
        emitted       = 0;
        overflow_seen = 1'b0;
        pending_results.delete();
    endtask

    task automatic write_shadow(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
        case (cfg_reg_t'(idx))
            REG_PATTERN_LOW:  pat_lo = val;
            REG_PATTERN_HIGH: pat_hi = val;
            REG_PATTERN_LEN:  pat_len = val[LEN_W-1:0];
            REG_REPLACE_LOW:  rep_lo = val;
            REG_REPLACE_HIGH: rep_hi = val;
            REG_REPLACE_LEN:  rep_len = val[LEN_W-1:0];
            REG_OUTPUT_LIMIT: out_limit = val[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    // data byte: dropped past the output limit, or silently past the result cap
    task automatic emit_char(input logic [7:0] c);
        slr_out_t r;
        if (emitted >= out_limit) begin
            overflow_seen = 1'b1;
            return;
        end
        if (step_results.size() >= DATA_CAP) return;
        emitted++;
        r          = '0;
        r.char_out = c;
        step_results.push_back(r);
    endtask

    task automatic emit_terminator();
        slr_out_t r;
        if (step_results.size() >= RESULT_CAP) return;
        r            = '0;
        r.string_end = 1'b1;
        step_results.push_back(r);
    endtask

    task automatic drop_head(input int unsigned k);
        if (k >= window_fill) begin
            window_fill = 0;
        end else begin
            for (int unsigned i = 0; i + k < window_fill; i++)
                window_bytes[i] = window_bytes[i + k];
            window_fill -= k;
        end
    endtask

    // window holds at least plen bytes: replace a match or pass the oldest byte
    task automatic resolve_front(input int plen);
        bit hit;
        int rlen;
        hit = 1'b1;
        for (int i = 0; i < plen; i++)
            if (window_bytes[i] != byte_pick(pat_lo, pat_hi, i)) hit = 1'b0;
        if (hit) begin
            rlen = clamp_len(rep_len, REPLACE_MAX);
            for (int i = 0; i < rlen; i++)
                emit_char(byte_pick(rep_lo, rep_hi, i));
            replace_count++;
            drop_head(plen);
        end else begin
            emit_char(window_bytes[0]);
            drop_head(1);
        end
    endtask

    task automatic predict_replace(input slr_in_t item);
        int plen;
        plen = clamp_len(pat_len, PATTERN_MAX);
        step_results.delete();
        byte_count++;

        // zero length passes through; otherwise shift into the window and compare
        if (plen == 0) begin
            for (int unsigned i = 0; i < window_fill && i < REG_BYTES; i++)
                emit_char(window_bytes[i]);
            window_fill = 0;
            emit_char(item.char_in);
        end else begin
            while (window_fill >= plen) resolve_front(plen);
            window_bytes[window_fill] = item.char_in;
            window_fill++;
            if (window_fill == plen) resolve_front(plen);
        end

        // final byte flushes the window and ends the string
        if (item.last_in) begin
            for (int unsigned i = 0; i < window_fill && i < REG_BYTES; i++)
                emit_char(window_bytes[i]);
            window_fill = 0;
            emit_terminator();
        end

        foreach (step_results[i]) begin
            step_results[i].overflow = overflow_seen;
            step_results[i].run_last = (i == step_results.size() - 1);
            pending_results.push_back(step_results[i]);
        end

        if (item.last_in) begin
            if (overflow_seen) overflow_strings++;
            emitted       = 0;
            overflow_seen = 1'b0;
        end
    endtask

    task automatic check_result(input slr_out_t got);
        slr_out_t want;
        result_count++;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result transfer with none expected, char %02h",
                                      got.char_out));
            return;
        end
        want = pending_results.pop_front();
        if (got.char_out !== want.char_out)
            report_mismatch($sformatf("char_out %02h, expected %02h",
                                      got.char_out, want.char_out));
        if (got.run_last !== want.run_last)
            report_mismatch($sformatf("run_last %b, expected %b (char %02h)",
                                      got.run_last, want.run_last, want.char_out));
        if (got.string_end !== want.string_end)
            report_mismatch($sformatf("string_end %b, expected %b (char %02h)",
                                      got.string_end, want.string_end, want.char_out));
        if (got.overflow !== want.overflow)
            report_mismatch($sformatf("overflow %b, expected %b (char %02h)",
                                      got.overflow, want.overflow, want.char_out));
    endtask

    // results first, so a result never matches an item taken at the same edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_model();
        end else begin
            if (m_valid && m_ready) check_result(m_payload);
            if (cfg_we) write_shadow(cfg_index, cfg_wdata);
            if (s_valid && s_ready) predict_replace(s_payload);
        end
        pending_count <= pending_results.size();
    end

endmodule

@@ test/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the streaming literal replace block
// ---------------------------------------------------------------------------
// Drives byte strings into the block under a series of pattern, replacement
// and output limit settings, written only while the block is idle. A short
// directed part covers pass-through, overlapping matches, full-length and
// saturated lengths, a pattern shortened mid-string, the result cap and the
// output limit. Random phases then send strings built mostly from pattern
// copies and prefixes. Both sides idle at random outside the last phases;
// the checker beside the block predicts and compares every result transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import slr_pkg::*;

    localparam int PATTERN_MAX   = PATTERN_MAX_DEF;
    localparam int REPLACE_MAX   = REPLACE_MAX_DEF;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 34;
    localparam int SETTLE_CYCLES = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef enum int {
        IDLE_SEND_LIGHT,
        IDLE_SEND_HEAVY,
        IDLE_NONE
    } idle_mode_t;

    logic     aclk      = 1'b0;
    logic     aresetn   = 1'b0;
    logic     cfg_we    = 1'b0;
    cfg_reg_t cfg_index = REG_PATTERN_LOW;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic     s_valid   = 1'b0;
    logic     s_ready;
    slr_in_t  s_payload = '0;
    logic     m_valid;
    logic     m_ready   = 1'b0;
    slr_out_t m_payload;

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_req_count = 0;
    int hold_taken     = 0;
    int hold_left      = 0;
    int cycle_count    = 0;

    int error_count, pending_count, byte_count, result_count, replace_count;
    int overflow_strings;

    // settings of the random phases
    int plen_tab [PHASES] = '{16, 0, 3, 31, 1, 5, 17, 2, 0, 16, 8, 4};
    int rlen_tab [PHASES] = '{0, 16, 2, 20, 3, 1, 31, 16, 0, 5, 0, 12};
    int limit_tab[PHASES] = '{256, 65535, 12, 40, 1, 256, 65535, 30, 3, 256, 65535, 20};

    always #2 aclk = ~aclk;

    stream_literal_replace #(
        .PATTERN_MAX (PATTERN_MAX),
        .REPLACE_MAX (REPLACE_MAX)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    slr_replace_checker #(
        .PATTERN_MAX (PATTERN_MAX),
        .REPLACE_MAX (REPLACE_MAX)
    ) checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_payload        (s_payload),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_payload        (m_payload),
        .error_count      (error_count),
        .pending_count    (pending_count),
        .byte_count       (byte_count),
        .result_count     (result_count),
        .replace_count    (replace_count),
        .overflow_strings (overflow_strings)
    );

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random stalls, or a long hold-off counted here
    always @(negedge aclk) begin
        if (hold_taken != hold_req_count) begin
            hold_taken = hold_req_count;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_SEND_LIGHT: begin
                send_idle_pct = 32;
                recv_idle_pct = 47;
            end
            IDLE_SEND_HEAVY: begin
                send_idle_pct = 47;
                recv_idle_pct = 32;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // one input transfer; valid stays up afterwards until the next idle or stop
    task automatic send_item(input logic [7:0] c, input logic last);
        slr_in_t item;
        item.char_in = c;
        item.last_in = last;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_payload <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop offering and wait until every predicted result has arrived
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
    endtask

    // drained, then room for an item still resolving without results
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic load_setup(input logic [63:0] plo, input logic [63:0] phi, input int plen,
                              input logic [63:0] rlo, input logic [63:0] rhi, input int rlen,
                              input int limit);
        write_reg(REG_PATTERN_LOW, plo);
        write_reg(REG_PATTERN_HIGH, phi);
        write_reg(REG_PATTERN_LEN, 64'(plen));
        write_reg(REG_REPLACE_LOW, rlo);
        write_reg(REG_REPLACE_HIGH, rhi);
        write_reg(REG_REPLACE_LEN, 64'(rlen));
        write_reg(REG_OUTPUT_LIMIT, 64'(limit));
    endtask

    initial begin
        logic [7:0]  alpha [4];
        logic [7:0]  pat_b [REG_BYTES];
        logic [7:0]  str_q[$];
        logic [63:0] plo, phi, rlo, rhi;
        int          eff_len, target, sent, cut;
        bit          paused;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings pass bytes through, extreme byte values
        set_idle(IDLE_SEND_LIGHT);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);

        // directed: overlapping occurrences take the leftmost, long replacement
        settle();
        rlo        = {$urandom, $urandom};
        rhi        = {$urandom, $urandom};
        rlo[15:0]  = 16'h00FF;
        load_setup(64'h0000_0000_0061_6261, 64'h0, 3, rlo, rhi, 16, 65535);
        send_item(8'h61, 1'b0);
        send_item(8'h62, 1'b0);
        send_item(8'h61, 1'b0);
        send_item(8'h62, 1'b0);
        send_item(8'h61, 1'b1);

        // directed: saturated pattern length, window held without results
        settle();
        plo = {8{8'h41}};
        load_setup(plo, plo, 31, rlo, rhi, 0, 256);
        repeat (15) send_item(8'h41, 1'b0);

        // directed: pattern shortened mid-string, every held byte matches,
        // replacement length saturates and the result cap trims the data
        settle();
        load_setup(plo, plo, 1, {$urandom, $urandom}, {$urandom, $urandom}, 20, 256);
        send_item(8'h41, 1'b1);

        // directed: pattern shortened to zero mid-string sends the window as is
        settle();
        load_setup(64'h0000_0000_7A79_7877, 64'h0, 4, rlo, rhi, 2, 256);
        send_item(8'h77, 1'b0);
        send_item(8'h78, 1'b0);
        send_item(8'h79, 1'b0);
        settle();
        write_reg(REG_PATTERN_LEN, 64'h0);
        send_item(8'h71, 1'b1);

        // directed: output limit of zero and of one
        settle();
        write_reg(REG_OUTPUT_LIMIT, 64'h0);
        send_item(8'h5A, 1'b1);
        settle();
        write_reg(REG_OUTPUT_LIMIT, 64'h1);
        send_item(8'h61, 1'b0);
        send_item(8'h62, 1'b1);

        // random phases: strings built from pattern copies, prefixes and noise
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            set_idle(idle_mode_t'(ph / 4));
            for (int k = 0; k < 4; k++) alpha[k] = 8'($urandom);
            for (int k = 0; k < REG_BYTES; k++) begin
                pat_b[k] = alpha[$urandom_range(3)];
                if (k < 8) plo[8*k +: 8] = pat_b[k];
                else phi[8*(k-8) +: 8] = pat_b[k];
            end
            load_setup(plo, phi, plen_tab[ph], {$urandom, $urandom}, {$urandom, $urandom},
                       rlen_tab[ph], limit_tab[ph]);
            eff_len = (plen_tab[ph] > REG_BYTES) ? REG_BYTES : plen_tab[ph];

            // long receiver hold-off so the block fills and stalls its input
            if (ph == 1) begin
                @(posedge aclk);
                hold_req_count++;
            end

            sent   = 0;
            paused = 1'b0;
            while (sent < PHASE_ITEMS) begin
                str_q.delete();
                // short strings only during the hold-off, so terminators add results
                target = (ph != 1 && $urandom_range(7) == 0) ? $urandom_range(30, 60)
                                                             : $urandom_range(1, 20);
                while (str_q.size() < target) begin
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4: begin
                            if (eff_len == 0) str_q.push_back(alpha[$urandom_range(3)]);
                            for (int k = 0; k < eff_len; k++) str_q.push_back(pat_b[k]);
                        end
                        5, 6: begin
                            cut = $urandom_range(eff_len);
                            for (int k = 0; k < cut; k++) str_q.push_back(pat_b[k]);
                        end
                        7, 8: str_q.push_back(alpha[$urandom_range(3)]);
                        default: str_q.push_back(8'($urandom));
                    endcase
                end
                foreach (str_q[i]) begin
                    if (sent < PHASE_ITEMS) begin
                        send_item(str_q[i], (i == str_q.size() - 1));
                        sent++;
                    end
                end
                // sender pause until the block has delivered everything
                if (ph == 6 && !paused && sent >= PHASE_ITEMS / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d input transfers, %0d result transfers, %0d replacements",
                 byte_count, result_count, replace_count);
        $display("%0d strings hit the output limit; pass-through, delete and capped runs",
                 overflow_strings);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
